[rtl/assert_macros.svh]
// Assertion macros shared by the classifier RTL.
// Define NO_ASSERTIONS to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[rtl/fmprc_pkg.sv]
// Types, codes and helpers of the first-match rule classifier.
// Used by the controller, the datapath and the top level; depends on nothing.
package fmprc_pkg;

  localparam int COUNT_W     = 6;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 6;
  localparam int RULE_IDX_W  = 5;

  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;
  localparam logic [7:0] PROTO_ICMP = 8'd1;

  localparam int WC_SPORT = 0;
  localparam int WC_DPORT = 1;
  localparam int WC_SIP   = 2;
  localparam int WC_DIP   = 3;

  typedef enum logic {
    ACT_WRITE    = 1'b0,
    ACT_CLASSIFY = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    CHAIN_IN  = 2'd0,
    CHAIN_OUT = 2'd1,
    CHAIN_FWD = 2'd2
  } chain_t;

  typedef enum logic [1:0] {
    PCLS_ANY  = 2'd0,
    PCLS_TCP  = 2'd1,
    PCLS_UDP  = 2'd2,
    PCLS_ICMP = 2'd3
  } proto_class_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_IN_COUNT    = 3'd0,
    CFG_OUT_COUNT   = 3'd1,
    CFG_FWD_COUNT   = 3'd2,
    CFG_IN_DEFAULT  = 3'd3,
    CFG_OUT_DEFAULT = 3'd4,
    CFG_FWD_DEFAULT = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                  action;
    logic [1:0]            chain;
    logic [RULE_IDX_W-1:0] rule_index;
    logic [31:0]           src_ip;
    logic [31:0]           dst_ip;
    logic [15:0]           src_port;
    logic [15:0]           dst_port;
    logic [7:0]            ip_proto;
    logic [1:0]            rule_proto_class;
    logic [3:0]            rule_wildcards;
    logic                  rule_verdict;
  } item_t;

  typedef struct packed {
    logic                  verdict;
    logic                  matched;
    logic [RULE_IDX_W-1:0] matched_rule;
  } result_t;

  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic        verdict;
    logic [3:0]  wildcards;
    logic [1:0]  proto_class;
  } rule_entry_t;

  typedef struct packed {
    logic accept;
    logic step;
    logic capture;
    logic publish;
  } dp_cmd_t;

  typedef struct packed {
    logic walk_req;
    logic walk_end;
    logic out_free;
  } dp_status_t;

  function automatic logic proto_ok(input logic [1:0] cls, input logic [7:0] proto);
    logic ok;
    unique case (cls)
      PCLS_TCP:  ok = (proto == PROTO_TCP);
      PCLS_UDP:  ok = (proto == PROTO_UDP);
      PCLS_ICMP: ok = (proto == PROTO_ICMP);
      default:   ok = 1'b1;
    endcase
    return ok;
  endfunction

endpackage

[rtl/fmprc_ctrl.sv]
// Controller of the rule classifier: item handshake and walk sequencing.
// Depends on fmprc_pkg; drives the datapath through dp_cmd_t.
`include "assert_macros.svh"
module fmprc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  fmprc_pkg::dp_status_t st,
  output fmprc_pkg::dp_cmd_t    cmd
);
  import fmprc_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item_ready = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.accept = 1'b1;
          if (st.walk_req) begin
            state_next = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        cmd.step = 1'b1;
        if (st.walk_end) begin
          cmd.capture = 1'b1;
          state_next  = ST_DONE;
        end
      end
      ST_DONE: begin
        if (st.out_free) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `ASSERT_IMPLIES(a_publish_free, clk, rst, cmd.publish, st.out_free)
  `ASSERT_NEXT(a_walk_entry, clk, rst, state == ST_IDLE && item_valid && st.walk_req, state == ST_WALK)
  `ASSERT_NEXT(a_walk_hold, clk, rst, state == ST_WALK && !st.walk_end, state == ST_WALK)

endmodule

[rtl/fmprc_datapath.sv]
// Datapath of the rule classifier: rule memory, walk counter, match logic,
// configuration registers and result register. Depends on fmprc_pkg.
`include "assert_macros.svh"
module fmprc_datapath #(
  parameter int RULES_PER_CHAIN = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  fmprc_pkg::item_t                    item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fmprc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [fmprc_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                                result_valid,
  input  logic                                result_ready,
  output fmprc_pkg::result_t                  result,
  input  fmprc_pkg::dp_cmd_t                  cmd,
  output fmprc_pkg::dp_status_t               st
);
  import fmprc_pkg::*;

  localparam int DEPTH = 3 * RULES_PER_CHAIN;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = (RULES_PER_CHAIN > 1) ? $clog2(RULES_PER_CHAIN) : 1;
  localparam int CNTW  = $clog2(RULES_PER_CHAIN + 1);
  localparam int CMPW  = (CNTW > COUNT_W) ? CNTW : COUNT_W;
  localparam logic [AW-1:0] BASE_OUT = AW'(RULES_PER_CHAIN);
  localparam logic [AW-1:0] BASE_FWD = AW'(2 * RULES_PER_CHAIN);

  rule_entry_t mem [DEPTH];
  rule_entry_t rd_data;

  logic [COUNT_W-1:0] in_count, out_count, fwd_count;
  logic               in_default, out_default, fwd_default;

  logic [31:0]   pkt_sip, pkt_dip;
  logic [15:0]   pkt_sport, pkt_dport;
  logic [7:0]    pkt_proto;
  logic          def_verdict;
  logic [AW-1:0] base;
  logic [CNTW-1:0] limit;
  logic [CNTW-1:0] issue;
  logic          pend;
  logic [IW-1:0] pend_idx;
  result_t       res;

  logic               chain_ok, idx_ok, wr_en;
  logic [AW-1:0]      sel_base, wr_addr, rd_addr;
  logic [COUNT_W-1:0] sel_count;
  logic               sel_default;
  logic [CNTW-1:0]    sel_limit;
  logic               issue_done, hit;
  rule_entry_t        wr_entry;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_count    <= '0;
      out_count   <= '0;
      fwd_count   <= '0;
      in_default  <= 1'b1;
      out_default <= 1'b1;
      fwd_default <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IN_COUNT:    in_count    <= cfg_data;
        CFG_OUT_COUNT:   out_count   <= cfg_data;
        CFG_FWD_COUNT:   fwd_count   <= cfg_data;
        CFG_IN_DEFAULT:  in_default  <= cfg_data[0];
        CFG_OUT_DEFAULT: out_default <= cfg_data[0];
        CFG_FWD_DEFAULT: fwd_default <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    chain_ok = (item.chain == CHAIN_IN) || (item.chain == CHAIN_OUT) ||
               (item.chain == CHAIN_FWD);
    unique case (item.chain)
      CHAIN_IN: begin
        sel_base    = '0;
        sel_count   = in_count;
        sel_default = in_default;
      end
      CHAIN_OUT: begin
        sel_base    = BASE_OUT;
        sel_count   = out_count;
        sel_default = out_default;
      end
      CHAIN_FWD: begin
        sel_base    = BASE_FWD;
        sel_count   = fwd_count;
        sel_default = fwd_default;
      end
      default: begin
        sel_base    = '0;
        sel_count   = '0;
        sel_default = 1'b1;
      end
    endcase
    if (CMPW'(sel_count) > CMPW'(RULES_PER_CHAIN)) begin
      sel_limit = CNTW'(RULES_PER_CHAIN);
    end else begin
      sel_limit = CNTW'(sel_count);
    end
  end

  assign idx_ok      = (32'(item.rule_index) < RULES_PER_CHAIN);
  assign wr_en       = cmd.accept && (item.action == ACT_WRITE) && chain_ok && idx_ok;
  assign wr_addr     = sel_base + AW'(item.rule_index);
  assign st.walk_req = (item.action == ACT_CLASSIFY) && chain_ok;

  assign wr_entry.src_ip      = item.src_ip;
  assign wr_entry.dst_ip      = item.dst_ip;
  assign wr_entry.src_port    = item.src_port;
  assign wr_entry.dst_port    = item.dst_port;
  assign wr_entry.verdict     = item.rule_verdict;
  assign wr_entry.wildcards   = item.rule_wildcards;
  assign wr_entry.proto_class = item.rule_proto_class;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  assign rd_addr = base + AW'(issue);

  always_ff @(posedge clk) begin
    if (cmd.step && !issue_done) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pkt_sip     <= item.src_ip;
      pkt_dip     <= item.dst_ip;
      pkt_sport   <= item.src_port;
      pkt_dport   <= item.dst_port;
      pkt_proto   <= item.ip_proto;
      def_verdict <= sel_default;
      base        <= sel_base;
      limit       <= sel_limit;
    end
    if (cmd.step && !issue_done) begin
      pend_idx <= IW'(issue);
    end
    if (cmd.capture) begin
      if (hit) begin
        res.verdict      <= rd_data.verdict;
        res.matched      <= 1'b1;
        res.matched_rule <= RULE_IDX_W'(pend_idx);
      end else begin
        res.verdict      <= def_verdict;
        res.matched      <= 1'b0;
        res.matched_rule <= '0;
      end
    end
    if (cmd.publish) begin
      result <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issue        <= '0;
      pend         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.accept) begin
        issue <= '0;
        pend  <= 1'b0;
      end else if (cmd.step) begin
        pend <= !issue_done;
        if (!issue_done) begin
          issue <= issue + CNTW'(1);
        end
      end
      if (cmd.publish) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  assign issue_done = (issue >= limit);
  assign hit = pend &&
               (rd_data.wildcards[WC_SPORT] || (pkt_sport == rd_data.src_port)) &&
               (rd_data.wildcards[WC_DPORT] || (pkt_dport == rd_data.dst_port)) &&
               (rd_data.wildcards[WC_SIP]   || (pkt_sip == rd_data.src_ip)) &&
               (rd_data.wildcards[WC_DIP]   || (pkt_dip == rd_data.dst_ip)) &&
               proto_ok(rd_data.proto_class, pkt_proto);

  assign st.walk_end = hit || (!pend && issue_done);
  assign st.out_free = !result_valid || result_ready;

  `ASSERT_IMPLIES(a_pend_in_limit, clk, rst, pend, CNTW'(pend_idx) < limit)
  `ASSERT_IMPLIES(a_issue_in_limit, clk, rst, cmd.step, issue <= limit)
  `ASSERT_NEXT(a_hit_marks_match, clk, rst, cmd.capture && hit, res.matched)

endmodule

[rtl/first_match_packet_rule_classifier.sv]
// First-match packet rule classifier with incoming, outgoing and forward
// chains. A write word stores a rule in the rule memory, which has one write
// port and one read port (3 x RULES_PER_CHAIN entries of 103 bits, not
// cleared at reset; only written rules may be classified over). A classify
// word walks its chain reading one rule per cycle from that memory: with
// count N (saturated to RULES_PER_CHAIN) it reads rules from 0 upward and
// stops at the first hit or after the last rule; the finished result then
// waits until the previous result has left the output register. A write or
// ignored word leaves the block idle, so the input stays ready for the next
// word. The result sits in an output register, so the next word is taken
// while it waits. Config writes are taken every cycle and must only happen
// while the block is idle.
module first_match_packet_rule_classifier #(
  parameter int RULES_PER_CHAIN = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  fmprc_pkg::item_t                    item,
  output logic                                result_valid,
  input  logic                                result_ready,
  output fmprc_pkg::result_t                  result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fmprc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [fmprc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import fmprc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  fmprc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .st         (st),
    .cmd        (cmd)
  );

  fmprc_datapath #(
    .RULES_PER_CHAIN (RULES_PER_CHAIN)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cmd          (cmd),
    .st           (st)
  );

endmodule

[tb/tb_first_match_packet_rule_classifier.sv]
// Self-checking bench for first_match_packet_rule_classifier: random rule tables,
// directed and random classify words, scoreboard against an in-bench rule walker.
// Depends on fmprc_pkg and the classifier RTL only.
module tb_first_match_packet_rule_classifier;
  timeunit 1ns;
  timeprecision 1ps;
  import fmprc_pkg::*;

  localparam int RULES        = 32;
  localparam int CHAINS       = 3;
  localparam int DRAIN_CYCLES = RULES + 8;
  localparam int DRAIN_LIMIT  = 100000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASES       = 7;
  localparam int PHASE_WORDS  = 80;
  localparam int PRESSURE_PHASE = 2;
  localparam int CALM_PHASE     = 4;

  localparam logic [1:0]             CHAIN_NONE   = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   item_valid   = 1'b0;
  logic                   item_ready;
  item_t                  item         = '0;
  logic                   result_valid;
  logic                   result_ready = 1'b0;
  result_t                result;
  logic                   cfg_valid    = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data     = '0;

  item_t       pending_words[$];
  result_t     expected_results[$];
  item_t       planned_rules [CHAINS*RULES];
  rule_entry_t rule_shadow [CHAINS*RULES];
  logic [COUNT_W-1:0] chain_len [CHAINS] = '{default: '0};
  logic               chain_dflt [CHAINS] = '{default: 1'b1};

  bit item_fire    = 1'b0;
  bit result_fire  = 1'b0;
  bit calm         = 1'b0;
  bit hold_request = 1'b0;
  bit hold_done    = 1'b0;
  int hold_left    = 0;
  int send_gap     = 0;
  int recv_gap     = 0;
  int mismatches   = 0;

  first_match_packet_rule_classifier #(.RULES_PER_CHAIN(RULES)) dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int live_rules(logic [1:0] c);
    return (chain_len[c] > RULES) ? RULES : int'(chain_len[c]);
  endfunction

  // walk from the top down so the lowest matching index wins
  function automatic result_t classify_packet(item_t w);
    rule_entry_t e;
    logic        hit;
    int          base;
    result_t     r;
    base = int'(w.chain) * RULES;
    r = '{verdict: chain_dflt[w.chain], matched: 1'b0, matched_rule: '0};
    for (int i = live_rules(w.chain) - 1; i >= 0; i--) begin
      e = rule_shadow[base + i];
      hit = (e.wildcards[WC_SPORT] || w.src_port == e.src_port) &&
            (e.wildcards[WC_DPORT] || w.dst_port == e.dst_port) &&
            (e.wildcards[WC_SIP]   || w.src_ip   == e.src_ip)   &&
            (e.wildcards[WC_DIP]   || w.dst_ip   == e.dst_ip);
      case (e.proto_class)
        PCLS_TCP:  hit = hit && (w.ip_proto == PROTO_TCP);
        PCLS_UDP:  hit = hit && (w.ip_proto == PROTO_UDP);
        PCLS_ICMP: hit = hit && (w.ip_proto == PROTO_ICMP);
        default:   ;
      endcase
      if (hit) r = '{verdict: e.verdict, matched: 1'b1, matched_rule: RULE_IDX_W'(i)};
    end
    return r;
  endfunction

  function automatic item_t any_word();
    item_t w;
    w.action           = 1'($urandom);
    w.chain            = 2'($urandom);
    w.rule_index       = RULE_IDX_W'($urandom);
    w.src_ip           = $urandom;
    w.dst_ip           = $urandom;
    w.src_port         = 16'($urandom);
    w.dst_port         = 16'($urandom);
    w.ip_proto         = 8'($urandom);
    w.rule_proto_class = 2'($urandom);
    w.rule_wildcards   = 4'($urandom);
    w.rule_verdict     = 1'($urandom);
    return w;
  endfunction

  function automatic item_t random_rule(logic [1:0] c, logic [RULE_IDX_W-1:0] idx);
    item_t w;
    w = any_word();
    w.action     = ACT_WRITE;
    w.chain      = c;
    w.rule_index = idx;
    return w;
  endfunction

  // packet that satisfies rule k of chain c as planned; earlier rules may still win
  function automatic item_t packet_for(logic [1:0] c, int k);
    item_t w;
    item_t rule;
    rule = planned_rules[int'(c) * RULES + k];
    w = any_word();
    w.action = ACT_CLASSIFY;
    w.chain  = c;
    if (!rule.rule_wildcards[WC_SPORT]) w.src_port = rule.src_port;
    if (!rule.rule_wildcards[WC_DPORT]) w.dst_port = rule.dst_port;
    if (!rule.rule_wildcards[WC_SIP])   w.src_ip   = rule.src_ip;
    if (!rule.rule_wildcards[WC_DIP])   w.dst_ip   = rule.dst_ip;
    case (rule.rule_proto_class)
      PCLS_TCP:  w.ip_proto = PROTO_TCP;
      PCLS_UDP:  w.ip_proto = PROTO_UDP;
      PCLS_ICMP: w.ip_proto = PROTO_ICMP;
      default:   ;
    endcase
    return w;
  endfunction

  function automatic logic [COUNT_W-1:0] pick_count();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return COUNT_W'(RULES);
      2:       return COUNT_W'($urandom_range(RULES + 1, 63));
      3:       return COUNT_W'(1);
      default: return COUNT_W'($urandom_range(1, RULES));
    endcase
  endfunction

  function automatic void push_word(item_t w);
    if (w.action == ACT_WRITE && w.chain != CHAIN_NONE)
      planned_rules[int'(w.chain) * RULES + int'(w.rule_index)] = w;
    pending_words.push_back(w);
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_IN_COUNT:    chain_len[CHAIN_IN]   = val;
      CFG_OUT_COUNT:   chain_len[CHAIN_OUT]  = val;
      CFG_FWD_COUNT:   chain_len[CHAIN_FWD]  = val;
      CFG_IN_DEFAULT:  chain_dflt[CHAIN_IN]  = val[0];
      CFG_OUT_DEFAULT: chain_dflt[CHAIN_OUT] = val[0];
      CFG_FWD_DEFAULT: chain_dflt[CHAIN_FWD] = val[0];
      default:         ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_chains(input logic [COUNT_W-1:0] n_in, n_out, n_fwd,
                            input logic d_in, d_out, d_fwd);
    write_reg(CFG_IN_COUNT,    n_in);
    write_reg(CFG_OUT_COUNT,   n_out);
    write_reg(CFG_FWD_COUNT,   n_fwd);
    write_reg(CFG_IN_DEFAULT,  CFG_DATA_W'(d_in));
    write_reg(CFG_OUT_DEFAULT, CFG_DATA_W'(d_out));
    write_reg(CFG_FWD_DEFAULT, CFG_DATA_W'(d_fwd));
  endtask

  // drain inputs and results, then let trailing writes retire
  task automatic settle();
    int waited;
    waited = 0;
    while ((pending_words.size() != 0 || item_valid || expected_results.size() != 0) &&
           waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_fire) begin
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
        item_valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        item       <= pending_words.pop_front();
        item_valid <= 1'b1;
        send_gap = pick_gap();
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : accept_side
    int slot;
    item_fire = !rst && item_valid && item_ready;
    if (item_fire && item.chain != CHAIN_NONE) begin
      slot = int'(item.chain) * RULES + int'(item.rule_index);
      if (item.action == ACT_WRITE) begin
        rule_shadow[slot] = '{src_ip: item.src_ip, dst_ip: item.dst_ip,
                              src_port: item.src_port, dst_port: item.dst_port,
                              verdict: item.rule_verdict, wildcards: item.rule_wildcards,
                              proto_class: item.rule_proto_class};
      end else begin
        expected_results.push_back(classify_packet(item));
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (hold_request && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (result_fire || $urandom_range(0, 19) == 0) recv_gap = pick_gap();
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        result_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap = recv_gap - 1;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_side
    result_t want;
    result_fire = !rst && result_valid && result_ready;
    if (result_fire) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: verdict=%0d matched=%0d rule=%0d",
                   result.verdict, result.matched, result.matched_rule);
      end else begin
        want = expected_results.pop_front();
        if (result.verdict !== want.verdict || result.matched !== want.matched ||
            result.matched_rule !== want.matched_rule) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected verdict=%0d matched=%0d rule=%0d, got verdict=%0d matched=%0d rule=%0d",
                     want.verdict, want.matched, want.matched_rule,
                     result.verdict, result.matched, result.matched_rule);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    item_t      w;
    int         r;
    int         b;
    int         k;
    int         counted;
    logic [1:0] c;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // populate every rule so no walk ever reads an unwritten entry
    for (int ch = 0; ch < CHAINS; ch++)
      for (int i = 0; i < RULES; i++)
        push_word(random_rule(2'(ch), RULE_IDX_W'(i)));
    settle();

    set_chains(COUNT_W'(RULES), '0, '1, 1'b0, 1'b1, 1'b0);

    w = random_rule(CHAIN_IN, 0);
    w.src_ip = '0; w.dst_ip = '0; w.src_port = '0; w.dst_port = '0;
    w.rule_proto_class = PCLS_ANY; w.rule_wildcards = '0; w.rule_verdict = 1'b0;
    push_word(w);
    w.rule_index = RULE_IDX_W'(RULES - 1);
    w.src_ip = '1; w.dst_ip = '1; w.src_port = '1; w.dst_port = '1; w.rule_verdict = 1'b1;
    push_word(w);
    w = random_rule(CHAIN_IN, 1);
    w.rule_proto_class = PCLS_TCP; w.rule_wildcards = '1; w.rule_verdict = 1'b1;
    push_word(w);
    w.rule_index = 2; w.rule_proto_class = PCLS_UDP; w.rule_verdict = 1'b0;
    push_word(w);
    w.rule_index = 3; w.rule_proto_class = PCLS_ICMP; w.rule_verdict = 1'b1;
    push_word(w);
    w.chain = CHAIN_NONE;
    push_word(w);

    w = any_word();
    w.action = ACT_CLASSIFY; w.chain = CHAIN_IN;
    w.src_ip = '0; w.dst_ip = '0; w.src_port = '0; w.dst_port = '0; w.ip_proto = '0;
    push_word(w);
    w.src_ip = '1; w.dst_ip = '1; w.src_port = '1; w.dst_port = '1; w.ip_proto = '1;
    push_word(w);
    w = any_word();
    w.action = ACT_CLASSIFY; w.chain = CHAIN_IN;
    w.ip_proto = PROTO_TCP;  push_word(w);
    w.ip_proto = PROTO_UDP;  push_word(w);
    w.ip_proto = PROTO_ICMP; push_word(w);
    w.ip_proto = 8'd200;     push_word(w);
    w.chain = CHAIN_OUT;     push_word(w);
    w.chain = CHAIN_FWD;     push_word(w);
    w.chain = CHAIN_NONE;    push_word(w);
    push_word(packet_for(CHAIN_FWD, RULES - 1));
    w = random_rule(CHAIN_FWD, 0);
    w.rule_wildcards = '1; w.rule_proto_class = PCLS_ANY; w.rule_verdict = 1'b1;
    push_word(w);
    w = any_word();
    w.action = ACT_CLASSIFY; w.chain = CHAIN_FWD;
    push_word(w);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      calm = (p == CALM_PHASE);
      set_chains(pick_count(), pick_count(), pick_count(),
                 1'($urandom), 1'($urandom), 1'($urandom));
      if (p == 1) begin
        write_reg(CFG_SPARE_LO, '1);
        write_reg(CFG_SPARE_HI, '0);
      end
      counted = 0;
      while (counted < PHASE_WORDS) begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          w = any_word();
          w.chain = CHAIN_NONE;
          push_word(w);
        end else begin
          counted++;
          if (r < 22) begin
            push_word(random_rule(2'($urandom_range(0, CHAINS - 1)),
                                  RULE_IDX_W'($urandom)));
          end else if (r < 75 && (live_rules(CHAIN_IN) + live_rules(CHAIN_OUT) +
                                  live_rules(CHAIN_FWD)) > 0) begin
            do c = 2'($urandom_range(0, CHAINS - 1)); while (live_rules(c) == 0);
            k = $urandom_range(0, live_rules(c) - 1);
            w = packet_for(c, k);
            if ($urandom_range(0, 3) == 0) begin
              b = $urandom_range(0, 31);
              case ($urandom_range(0, 4))
                0: w.src_ip[b] = ~w.src_ip[b];
                1: w.dst_ip[b] = ~w.dst_ip[b];
                2: w.src_port[b % 16] = ~w.src_port[b % 16];
                3: w.dst_port[b % 16] = ~w.dst_port[b % 16];
                default: w.ip_proto[b % 8] = ~w.ip_proto[b % 8];
              endcase
            end
            push_word(w);
          end else begin
            w = any_word();
            w.action = ACT_CLASSIFY;
            w.chain  = 2'($urandom_range(0, CHAINS - 1));
            case ($urandom_range(0, 3))
              0:       w.ip_proto = PROTO_TCP;
              1:       w.ip_proto = PROTO_UDP;
              2:       w.ip_proto = PROTO_ICMP;
              default: ;
            endcase
            push_word(w);
          end
        end
      end
      if (p == PRESSURE_PHASE) hold_request = 1'b1;
    end

    settle();
    mismatches += expected_results.size();
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/fmprc_pkg.sv
rtl/fmprc_ctrl.sv
rtl/fmprc_datapath.sv
rtl/first_match_packet_rule_classifier.sv
tb/tb_first_match_packet_rule_classifier.sv
